// File: design/gsbf_pkg.sv
package gsbf_pkg;

    localparam int unsigned MAX_BLOCK_BYTES = 65535;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [15:0] MAX_BLOCK_LEN = 16'(MAX_BLOCK_BYTES);

    // gzip member header bytes that are not zero
    localparam logic [7:0] GZ_ID1    = 8'h1F;
    localparam logic [7:0] GZ_ID2    = 8'h8B;
    localparam logic [7:0] GZ_CM     = 8'h08;
    localparam logic [7:0] GZ_OS     = 8'hFF;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] total_length;
        logic [7:0]  data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_file;
    } t_out;

    typedef enum logic [1:0] {
        SEG_GZ,
        SEG_BLK,
        SEG_DATA,
        SEG_TRL
    } t_seg;

    typedef struct packed {
        logic trl;
        logic data;
        logic blk;
        logic gz;
    } t_segs;

    // everything the sequencer needs to emit the bytes of one input item
    typedef struct packed {
        t_segs       segs;
        logic        final_flag;
        logic [15:0] blk_len;
        logic [7:0]  data_byte;
        logic [31:0] crc_out;
        logic [31:0] length;
    } t_job;

endpackage

// File: design/gsbf_core.sv
module gsbf_core
    import gsbf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_in  i_in,
    output t_job o_job
);

    logic [31:0] r_crc,      n_crc;
    logic [31:0] r_bytes_rem, n_bytes_rem;
    logic [15:0] r_blk_rem,  n_blk_rem;
    logic [31:0] r_strm_len, n_strm_len;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'b0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    logic [31:0] crc_next;
    logic        blk_open;
    logic        fits;
    logic [15:0] blk_len;
    logic [15:0] blk_base;

    always_comb begin
        crc_next = crc_byte(r_crc, i_in.data_byte);
        blk_open = (r_blk_rem == 16'd0);
        fits     = (r_bytes_rem <= 32'(MAX_BLOCK_BYTES));
        blk_len  = fits ? r_bytes_rem[15:0] : MAX_BLOCK_LEN;
        blk_base = blk_open ? blk_len : r_blk_rem;

        n_crc       = r_crc;
        n_bytes_rem = r_bytes_rem;
        n_blk_rem   = r_blk_rem;
        n_strm_len  = r_strm_len;

        o_job            = '0;
        o_job.data_byte  = i_in.data_byte;
        o_job.length     = r_strm_len;

        if (i_in.operation == OP_START) begin
            n_crc       = CRC_INIT;
            n_strm_len  = i_in.total_length;
            n_bytes_rem = i_in.total_length;
            n_blk_rem   = 16'd0;
            o_job.segs.gz = 1'b1;
            // empty stream: one empty final block and the trailer straight away
            if (i_in.total_length == 32'd0) begin
                o_job.segs.blk   = 1'b1;
                o_job.segs.trl   = 1'b1;
                o_job.final_flag = 1'b1;
                o_job.blk_len    = 16'd0;
                o_job.crc_out    = 32'd0;
                o_job.length     = 32'd0;
            end
        end else if (r_bytes_rem != 32'd0) begin
            n_crc       = crc_next;
            n_bytes_rem = r_bytes_rem - 32'd1;
            n_blk_rem   = blk_base - 16'd1;
            o_job.segs.blk   = blk_open;
            o_job.segs.data  = 1'b1;
            o_job.segs.trl   = (r_bytes_rem == 32'd1);
            o_job.final_flag = fits;
            o_job.blk_len    = blk_len;
            o_job.crc_out    = ~crc_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_bytes_rem <= '0;
            r_blk_rem   <= '0;
            r_strm_len  <= '0;
        end else if (i_load) begin
            r_crc       <= n_crc;
            r_bytes_rem <= n_bytes_rem;
            r_blk_rem   <= n_blk_rem;
            r_strm_len  <= n_strm_len;
        end
    end

    a_blk_within_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_blk_rem != 16'd0) |-> ({16'b0, r_blk_rem} <= r_bytes_rem))
        else $error("block count exceeds remaining stream bytes");

    a_blk_le_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_rem <= r_strm_len)
        else $error("remaining bytes exceed stream length");

    a_start_resets_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_in.operation == OP_START) |=> (r_crc == CRC_INIT && r_blk_rem == 16'd0))
        else $error("start did not reinitialise stream state");

endmodule

// File: design/gsbf_emit.sv
module gsbf_emit
    import gsbf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_job i_job,
    output logic o_ready,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    logic       r_busy, n_busy;
    t_seg       r_seg,  n_seg;
    logic [3:0] r_cnt,  n_cnt;
    t_segs      r_left, n_left;
    t_job       r_job;
    logic       r_oval, n_oval;
    t_out       r_out,  n_out;

    function automatic t_seg first_seg(input t_segs s);
        if (s.gz)       return SEG_GZ;
        else if (s.blk) return SEG_BLK;
        else if (s.data) return SEG_DATA;
        else            return SEG_TRL;
    endfunction

    function automatic t_segs drop_seg(input t_segs s, input t_seg g);
        t_segs r;
        r = s;
        case (g)
            SEG_GZ:   r.gz   = 1'b0;
            SEG_BLK:  r.blk  = 1'b0;
            SEG_DATA: r.data = 1'b0;
            SEG_TRL:  r.trl  = 1'b0;
            default:  r      = s;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] seg_last(input t_seg g);
        case (g)
            SEG_GZ:   return 4'd9;
            SEG_BLK:  return 4'd4;
            SEG_DATA: return 4'd0;
            SEG_TRL:  return 4'd7;
            default:  return 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] seg_byte(input t_seg g, input logic [3:0] c, input t_job j);
        logic [7:0] b;
        b = 8'h00;
        case (g)
            SEG_GZ: begin
                case (c)
                    4'd0:    b = GZ_ID1;
                    4'd1:    b = GZ_ID2;
                    4'd2:    b = GZ_CM;
                    4'd9:    b = GZ_OS;
                    default: b = 8'h00;
                endcase
            end
            SEG_BLK: begin
                case (c)
                    4'd0:    b = {7'b0, j.final_flag};
                    4'd1:    b = j.blk_len[7:0];
                    4'd2:    b = j.blk_len[15:8];
                    4'd3:    b = ~j.blk_len[7:0];
                    4'd4:    b = ~j.blk_len[15:8];
                    default: b = 8'h00;
                endcase
            end
            SEG_DATA: b = j.data_byte;
            SEG_TRL: begin
                case (c)
                    4'd0:    b = j.crc_out[7:0];
                    4'd1:    b = j.crc_out[15:8];
                    4'd2:    b = j.crc_out[23:16];
                    4'd3:    b = j.crc_out[31:24];
                    4'd4:    b = j.length[7:0];
                    4'd5:    b = j.length[15:8];
                    4'd6:    b = j.length[23:16];
                    4'd7:    b = j.length[31:24];
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    logic out_load;
    logic fire;
    logic seg_end;
    logic job_end;

    always_comb begin
        out_load = !r_oval || !i_out_stall;
        fire     = r_busy && out_load;
        seg_end  = (r_cnt == seg_last(r_seg));
        job_end  = seg_end && (r_left == '0);
        o_ready  = !r_busy || (fire && job_end);

        n_busy = r_busy;
        n_seg  = r_seg;
        n_cnt  = r_cnt;
        n_left = r_left;
        n_oval = r_oval;
        n_out  = r_out;

        if (fire) begin
            n_oval            = 1'b1;
            n_out.out_byte    = seg_byte(r_seg, r_cnt, r_job);
            n_out.last_of_run = job_end;
            n_out.end_of_file = (r_seg == SEG_TRL) && seg_end;
        end else if (out_load) begin
            n_oval = 1'b0;
        end

        if (i_load) begin
            n_busy = (i_job.segs != '0);
            n_seg  = first_seg(i_job.segs);
            n_left = drop_seg(i_job.segs, first_seg(i_job.segs));
            n_cnt  = 4'd0;
        end else if (fire) begin
            if (job_end) begin
                n_busy = 1'b0;
            end else if (seg_end) begin
                n_seg  = first_seg(r_left);
                n_left = drop_seg(r_left, first_seg(r_left));
                n_cnt  = 4'd0;
            end else begin
                n_cnt = r_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seg  <= SEG_GZ;
            r_cnt  <= '0;
            r_left <= '0;
            r_oval <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_seg  <= n_seg;
            r_cnt  <= n_cnt;
            r_left <= n_left;
            r_oval <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_load) begin
            r_job <= i_job;
        end
    end

    assign o_out_valid = r_oval;
    assign o_out       = r_out;

    a_load_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready)
        else $error("job loaded while sequencer busy");

    a_busy_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !fire) |=> r_busy)
        else $error("job dropped without emitting");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= seg_last(r_seg)))
        else $error("segment byte count out of range");

    a_eof_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && r_out.end_of_file) |-> r_out.last_of_run)
        else $error("end of file not on last byte of run");

endmodule

// File: design/gzip_stored_block_framer_top.sv
// channel | direction | handshake                     | payload
// --------+-----------+-------------------------------+-----------------
// in      | input     | i_in_valid / o_in_stall       | i_in  (t_in)
// out     | output    | o_out_valid / i_out_stall     | o_out (t_out)
//
// One output byte per cycle unless the output stalls. A data byte that opens a block
// first emits the block header; the last byte adds the trailer. A start emits the
// gzip header, and for an empty stream also an empty final block and the trailer.
// The input stalls while the sequencer is busy, except on its final byte.
// Synchronous reset clears the CRC to all ones and the counters to zero.
module gzip_stored_block_framer_top
    import gsbf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    logic ready;
    logic load;
    t_job job;

    assign o_in_stall = !ready;
    assign load       = i_in_valid && ready;

    gsbf_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_in    (i_in),
        .o_job   (job)
    );

    gsbf_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_job       (job),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import gsbf_pkg::*;

    localparam logic [7:0] BLK_MORE  = 8'h00;
    localparam logic [7:0] BLK_FINAL = 8'h01;
    localparam logic [79:0] GZ_HEADER = {GZ_ID1, GZ_ID2, GZ_CM, 48'h0, GZ_OS};
    // typed rows: bytes packed MSB first
    localparam int TYPED_MAX = 23;
    localparam logic [183:0] HDR_ONLY   = {GZ_HEADER, 104'h0};
    localparam logic [183:0] EMPTY_FILE = {GZ_HEADER, BLK_FINAL, 16'h0000, 16'hFFFF, 64'h0};
    localparam int PREDICTED = -1;

    typedef struct {
        t_in              item;
        int               n_typed;
        logic [183:0]     typed;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    gzip_stored_block_framer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #1 i_clk = ~i_clk;

    int src_idle = 17;
    int snk_idle = 47;
    int n_errors = 0;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < snk_idle);
    end

    // framer state as seen from outside
    logic [31:0] crc_acc;
    logic [31:0] bytes_left;
    logic [15:0] blk_left;
    logic [31:0] stream_len;

    t_out framed[$];
    t_out gz_expected[$];
    t_row stim_table[$];

    function automatic void put_byte(logic [7:0] b, logic eof);
        framed.push_back('{out_byte: b, last_of_run: 1'b0, end_of_file: eof});
    endfunction

    function automatic void put_le32(logic [31:0] v, logic eof);
        put_byte(v[7:0], 1'b0);
        put_byte(v[15:8], 1'b0);
        put_byte(v[23:16], 1'b0);
        put_byte(v[31:24], eof);
    endfunction

    function automatic void put_block_hdr(logic [15:0] len, logic fin);
        put_byte(fin ? BLK_FINAL : BLK_MORE, 1'b0);
        put_byte(len[7:0], 1'b0);
        put_byte(len[15:8], 1'b0);
        put_byte(~len[7:0], 1'b0);
        put_byte(~len[15:8], 1'b0);
    endfunction

    function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
        return r;
    endfunction

    function automatic void put_trailer();
        put_le32(crc_acc ^ CRC_INIT, 1'b0);
        put_le32(stream_len, 1'b1);
    endfunction

    // bytes of the gzip file caused by one accepted item, left in framed
    function automatic void gzip_frame(t_in it);
        logic [31:0] blk;
        framed.delete();
        if (it.operation == OP_START) begin
            crc_acc    = CRC_INIT;
            stream_len = it.total_length;
            bytes_left = it.total_length;
            blk_left   = '0;
            for (int i = 0; i < 10; i++)
                put_byte(GZ_HEADER[79 - 8*i -: 8], 1'b0);
            if (it.total_length == 0) begin
                put_block_hdr(16'h0, 1'b1);
                put_trailer();
            end
        end else if (bytes_left != 0) begin
            if (blk_left == 0) begin
                blk = (bytes_left > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : bytes_left;
                put_block_hdr(blk[15:0], blk == bytes_left);
                blk_left = blk[15:0];
            end
            put_byte(it.data_byte, 1'b0);
            crc_acc = crc_byte(crc_acc, it.data_byte);
            bytes_left--;
            blk_left--;
            if (bytes_left == 0)
                put_trailer();
        end
        if (framed.size() > 0)
            framed[framed.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic t_row row(logic op, logic [31:0] len, logic [7:0] d, int n,
                                 logic [183:0] typed);
        return '{item: '{operation: op, total_length: len, data_byte: d},
                 n_typed: n, typed: typed};
    endfunction

    task automatic send_item(input t_in it, input int n_typed, input logic [183:0] typed,
                             output int n_res);
        bit taken;
        while ($urandom_range(0, 99) < src_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        taken = 1'b0;
        n_res = 0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (o_in_stall === 1'b0);
            if (taken) begin
                // transfer lands on the coming edge
                gzip_frame(it);
                n_res = framed.size();
                if (n_typed == PREDICTED) begin
                    foreach (framed[i])
                        gz_expected.push_back(framed[i]);
                end else begin
                    for (int i = 0; i < n_typed; i++)
                        gz_expected.push_back('{out_byte: typed[183 - 8*i -: 8],
                                                last_of_run: (i == n_typed - 1),
                                                end_of_file: (n_typed == TYPED_MAX) &&
                                                             (i == n_typed - 1)});
                end
            end
            @(posedge i_clk);
        end
    endtask

    // output side: sample between edges, check on the transfer edge
    logic out_take = 1'b0;
    t_out out_seen;

    always @(negedge i_clk) begin
        out_take = i_rst_n && (o_out_valid === 1'b1) && (i_out_stall === 1'b0);
        out_seen = o_out;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (out_take) begin
            if (gz_expected.size() == 0) begin
                $display("%0t: byte with nothing expected: byte %h last %b eof %b",
                         $time, out_seen.out_byte, out_seen.last_of_run,
                         out_seen.end_of_file);
                n_errors++;
            end else begin
                want = gz_expected.pop_front();
                if (out_seen.out_byte !== want.out_byte ||
                    out_seen.last_of_run !== want.last_of_run ||
                    out_seen.end_of_file !== want.end_of_file) begin
                    $display("%0t: expected byte %h last %b eof %b, got byte %h last %b eof %b",
                             $time, want.out_byte, want.last_of_run, want.end_of_file,
                             out_seen.out_byte, out_seen.last_of_run, out_seen.end_of_file);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        int          n;
        int          n_rand;
        int          n_data;
        int          kind;
        int          r;
        logic [31:0] len;
        t_in         it;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        crc_acc    = CRC_INIT;
        bytes_left = '0;
        blk_left   = '0;
        stream_len = '0;

        stim_table.push_back(row(OP_DATA,  32'h0000_0005, 8'h12, 0, '0));          // no stream open
        stim_table.push_back(row(OP_START, 32'h0,         8'hFF, 23, EMPTY_FILE)); // empty stream
        stim_table.push_back(row(OP_DATA,  32'hFFFF_FFFF, 8'hFF, 0, '0));          // after trailer
        stim_table.push_back(row(OP_START, 32'h1,         8'h00, 10, HDR_ONLY));
        stim_table.push_back(row(OP_DATA,  32'h0,         8'h00, PREDICTED, '0));
        stim_table.push_back(row(OP_START, 32'h3,         8'h77, 10, HDR_ONLY));
        stim_table.push_back(row(OP_DATA,  32'h0,         8'hFF, PREDICTED, '0));
        stim_table.push_back(row(OP_DATA,  32'h1234_5678, 8'hA5, PREDICTED, '0));
        stim_table.push_back(row(OP_DATA,  32'h0,         8'h5A, PREDICTED, '0));
        stim_table.push_back(row(OP_START, 32'hFFFF_FFFF, 8'h00, 10, HDR_ONLY));
        stim_table.push_back(row(OP_DATA,  32'h0,         8'h3C, PREDICTED, '0)); // non-final block
        stim_table.push_back(row(OP_DATA,  32'h0,         8'hC3, PREDICTED, '0));
        stim_table.push_back(row(OP_START, 32'h2,         8'h00, 10, HDR_ONLY)); // abandons stream
        stim_table.push_back(row(OP_DATA,  32'h0,         8'h80, PREDICTED, '0));
        stim_table.push_back(row(OP_START, 32'h0,         8'h01, 23, EMPTY_FILE));
        stim_table.push_back(row(OP_START, 32'hAAAA_AAAA, 8'hAA, 10, HDR_ONLY));
        stim_table.push_back(row(OP_DATA,  32'h5555_5555, 8'h55, PREDICTED, '0));
        stim_table.push_back(row(OP_START, 32'h5555_5555, 8'h55, 10, HDR_ONLY));
        stim_table.push_back(row(OP_DATA,  32'hAAAA_AAAA, 8'hAA, PREDICTED, '0));
        stim_table.push_back(row(OP_START, 32'h0,         8'h00, 23, EMPTY_FILE));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[k])
            send_item(stim_table[k].item, stim_table[k].n_typed, stim_table[k].typed, n);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 17 : (ph == 1) ? 47 : 0;
            snk_idle = (ph == 0) ? 47 : (ph == 1) ? 17 : 0;
            n_rand = 0;
            while (n_rand < 150) begin
                kind = $urandom_range(0, 99);
                if (kind < 8) begin
                    // stray byte, ignored unless a stream is still open
                    it = '{operation: OP_DATA, total_length: $urandom,
                           data_byte: 8'($urandom_range(0, 255))};
                    send_item(it, PREDICTED, '0, n);
                    if (n > 0)
                        n_rand++;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        len = $urandom_range(0, 12);
                    else if (r < 90)
                        len = $urandom_range(13, 80);
                    else
                        len = $urandom;
                    it = '{operation: OP_START, total_length: len,
                           data_byte: 8'($urandom_range(0, 255))};
                    send_item(it, PREDICTED, '0, n);
                    n_rand++;
                    n_data = len;
                    if (len > 80 || $urandom_range(0, 99) < 12)
                        n_data = $urandom_range(0, (len > 8) ? 8 : len);
                    repeat (n_data) begin
                        it = '{operation: OP_DATA, total_length: $urandom,
                               data_byte: 8'($urandom_range(0, 255))};
                        send_item(it, PREDICTED, '0, n);
                        n_rand++;
                    end
                end
            end
        end
        i_in_valid <= 1'b0;

        while (gz_expected.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (n_errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
